### sv/acfm_pkg.sv
package acfm_pkg;

    localparam int CNT_W = 25;
    localparam int SYM_W = 9;
    localparam int TGT_W = 24;
    localparam int KIND_W = 2;

    typedef enum logic [1:0] {
        KIND_SYM   = 2'd0,
        KIND_FREQ  = 2'd1,
        KIND_RESET = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Decoded command passed from the front end to the table engine.
    typedef struct packed {
        kind_t             kind;
        logic [SYM_W-1:0]  symbol;
        logic [TGT_W-1:0]  target_freq;
        logic              do_update;
    } cmd_t;

    typedef struct packed {
        logic              found;
        logic [SYM_W-1:0]  out_symbol;
        logic [CNT_W-1:0]  low_bound;
        logic [CNT_W-1:0]  high_bound;
        logic [CNT_W-1:0]  total;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_LOW_RD,
        ST_LOW_WAIT,
        ST_TOT_RD,
        ST_TOT_WAIT,
        ST_EMIT,
        ST_INC_RD,
        ST_INC_WR,
        ST_RS_RD,
        ST_RS_WR
    } eng_state_t;

endpackage

### sv/acfm_if.sv
interface acfm_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [8:0]                 symbol;
    logic [23:0]                target_freq;
    logic                       do_update;

    modport source (output valid, kind, symbol, target_freq, do_update, input ready);
    modport sink (input valid, kind, symbol, target_freq, do_update, output ready);
endinterface

interface acfm_res_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [8:0]                 out_symbol;
    logic [24:0]                low_bound;
    logic [24:0]                high_bound;
    logic [24:0]                total;

    modport source (output valid, found, out_symbol, low_bound, high_bound, total,
                    input ready);
    modport sink (input valid, found, out_symbol, low_bound, high_bound, total,
                  output ready);
endinterface

### sv/acfm_ram.sv
module acfm_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 258
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/acfm_front.sv
// Two-entry command queue: takes transactions and hands decoded commands on.
module acfm_front (
    input  logic              clk,
    input  logic              rst_n,
    acfm_cmd_if.sink          cmd,
    output logic              cmd_valid,
    output acfm_pkg::cmd_t    cmd_data,
    input  logic              cmd_take
);

    acfm_pkg::cmd_t q_reg [2];
    logic [1:0]     cnt_reg;
    logic           rd_reg;
    logic           wr_reg;
    logic           push;
    logic           pop;
    acfm_pkg::cmd_t in_cmd;

    assign cmd.ready = (cnt_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign pop       = cmd_take && cmd_valid;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rd_reg];

    always_comb
    begin
        in_cmd.kind        = acfm_pkg::kind_t'(cmd.kind);
        in_cmd.symbol      = cmd.symbol;
        in_cmd.target_freq = cmd.target_freq;
        in_cmd.do_update   = cmd.do_update;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### sv/acfm_engine.sv
// Table engine: walks the cumulative table in one RAM, one entry per
// read or write cycle.
module acfm_engine #(
    parameter int TABLE_ENTRIES = 258
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [acfm_pkg::CNT_W-1:0] freq_limit,
    input  logic                      cmd_valid,
    input  acfm_pkg::cmd_t            cmd_data,
    output logic                      cmd_take,
    output logic                      res_valid,
    output acfm_pkg::res_t            res_data,
    input  logic                      res_ready
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam logic [AW-1:0] LAST_SYM = AW'(TABLE_ENTRIES - 2);

    acfm_pkg::eng_state_t state_reg, state_next;
    acfm_pkg::cmd_t       cmd_reg;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        sym_reg, sym_next;
    logic [acfm_pkg::CNT_W-1:0] prev_reg, prev_next;
    logic [acfm_pkg::CNT_W-1:0] low_reg, low_next;
    logic [acfm_pkg::CNT_W-1:0] high_reg, high_next;
    logic                 hit_reg, hit_next;
    logic                 boot_reg, boot_next;
    logic                 res_valid_reg;
    acfm_pkg::res_t       res_reg;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [acfm_pkg::CNT_W-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic [acfm_pkg::CNT_W-1:0] rd_data;
    logic [acfm_pkg::CNT_W-1:0] half;
    logic [acfm_pkg::CNT_W-1:0] scaled;
    logic                 emit;

    acfm_ram #(.WIDTH(acfm_pkg::CNT_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign half   = acfm_pkg::CNT_W'(({1'b0, rd_data} + 26'd1) >> 1);
    assign scaled = (idx_reg != '0 && half <= prev_reg) ? prev_reg + 1'b1 : half;
    assign emit   = (state_reg == acfm_pkg::ST_EMIT) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sym_next   = sym_reg;
        prev_next  = prev_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        hit_next   = hit_reg;
        boot_next  = boot_reg;
        unique case (state_reg)
            acfm_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    hit_next = 1'b0;
                    unique case (cmd_data.kind)
                        acfm_pkg::KIND_SYM:
                        begin
                            if (int'(cmd_data.symbol) <= int'(LAST_SYM))
                            begin
                                hit_next   = 1'b1;
                                sym_next   = AW'(cmd_data.symbol);
                                idx_next   = AW'(cmd_data.symbol);
                                state_next = acfm_pkg::ST_LOW_RD;
                            end
                            else
                            begin
                                state_next = acfm_pkg::ST_EMIT;
                            end
                        end
                        acfm_pkg::KIND_FREQ:
                        begin
                            idx_next   = AW'(1);
                            prev_next  = '0;
                            state_next = acfm_pkg::ST_SCAN_RD;
                        end
                        acfm_pkg::KIND_RESET:
                        begin
                            idx_next   = '0;
                            state_next = acfm_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = acfm_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            acfm_pkg::ST_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    // The pass that follows reset gives no result transaction.
                    boot_next  = 1'b0;
                    state_next = boot_reg ? acfm_pkg::ST_IDLE : acfm_pkg::ST_EMIT;
                end
            end
            acfm_pkg::ST_SCAN_RD:
            begin
                state_next = acfm_pkg::ST_SCAN_CHK;
            end
            acfm_pkg::ST_SCAN_CHK:
            begin
                // rd_data is entry idx; prev_reg holds entry idx-1.
                if ({1'b0, cmd_reg.target_freq} < rd_data)
                begin
                    hit_next   = 1'b1;
                    sym_next   = idx_reg - 1'b1;
                    low_next   = prev_reg;
                    high_next  = rd_data;
                    state_next = acfm_pkg::ST_TOT_RD;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = acfm_pkg::ST_EMIT;
                end
                else
                begin
                    prev_next  = rd_data;
                    idx_next   = idx_reg + 1'b1;
                    state_next = acfm_pkg::ST_SCAN_RD;
                end
            end
            acfm_pkg::ST_LOW_RD:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = acfm_pkg::ST_LOW_WAIT;
            end
            acfm_pkg::ST_LOW_WAIT:
            begin
                low_next   = rd_data;
                state_next = acfm_pkg::ST_TOT_RD;
            end
            acfm_pkg::ST_TOT_RD:
            begin
                if (hit_reg && cmd_reg.kind == acfm_pkg::KIND_SYM)
                begin
                    high_next = rd_data;
                end
                state_next = acfm_pkg::ST_TOT_WAIT;
            end
            acfm_pkg::ST_TOT_WAIT:
            begin
                prev_next  = rd_data;
                state_next = acfm_pkg::ST_EMIT;
            end
            acfm_pkg::ST_EMIT:
            begin
                if (!res_valid_reg)
                begin
                    if (hit_reg && cmd_reg.do_update)
                    begin
                        idx_next   = sym_reg + 1'b1;
                        state_next = acfm_pkg::ST_INC_RD;
                    end
                    else
                    begin
                        state_next = acfm_pkg::ST_IDLE;
                    end
                end
            end
            acfm_pkg::ST_INC_RD:
            begin
                state_next = acfm_pkg::ST_INC_WR;
            end
            acfm_pkg::ST_INC_WR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    prev_next = (rd_data < acfm_pkg::CNT_MAX) ? rd_data + 1'b1 : rd_data;
                    if (((rd_data < acfm_pkg::CNT_MAX) ? rd_data + 1'b1 : rd_data)
                        >= freq_limit)
                    begin
                        idx_next   = '0;
                        state_next = acfm_pkg::ST_RS_RD;
                    end
                    else
                    begin
                        state_next = acfm_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = acfm_pkg::ST_INC_RD;
                end
            end
            acfm_pkg::ST_RS_RD:
            begin
                state_next = acfm_pkg::ST_RS_WR;
            end
            acfm_pkg::ST_RS_WR:
            begin
                prev_next = scaled;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = acfm_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = acfm_pkg::ST_RS_RD;
                end
            end
            default:
            begin
                state_next = acfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_take = (state_reg == acfm_pkg::ST_IDLE) && cmd_valid;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = '0;
        rd_addr  = idx_reg;
        unique case (state_reg)
            acfm_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = acfm_pkg::CNT_W'(idx_reg);
            end
            acfm_pkg::ST_TOT_RD:
            begin
                rd_addr = LAST_IDX;
            end
            acfm_pkg::ST_INC_WR:
            begin
                wr_en   = 1'b1;
                wr_data = (rd_data < acfm_pkg::CNT_MAX) ? rd_data + 1'b1 : rd_data;
            end
            acfm_pkg::ST_RS_WR:
            begin
                wr_en   = 1'b1;
                wr_data = scaled;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == acfm_pkg::ST_IDLE && cmd_valid)
        begin
            cmd_reg <= cmd_data;
        end
        if (emit)
        begin
            res_reg.found      <= hit_reg;
            res_reg.out_symbol <= hit_reg ? acfm_pkg::SYM_W'(sym_reg) : '0;
            res_reg.low_bound  <= hit_reg ? low_reg : '0;
            res_reg.high_bound <= hit_reg ? high_reg : '0;
            res_reg.total      <= hit_reg ? prev_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acfm_pkg::ST_CLEAR;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
            sym_reg       <= '0;
            prev_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            hit_reg       <= 1'b0;
            boot_reg      <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sym_reg   <= sym_next;
            prev_reg  <= prev_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            hit_reg   <= hit_next;
            boot_reg  <= boot_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/adaptive_cum_freq_model_unit.sv
// Adaptive cumulative frequency model for an arithmetic coder.
// Channel cmd (sink): kind, symbol, target_freq, do_update. kind selects a
// query by symbol, a query by cumulative value, or a table reset.
// Channel res (source): one transaction per command with found, out_symbol,
// low_bound, high_bound and total, the bounds taken before any update.
// freq_limit is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle; the block does not enforce it. A two-deep
// queue takes commands while the table engine is busy. The engine owns
// one RAM of TABLE_ENTRIES words and takes a new command only when idle.
// A query by symbol reads its low and high bound and the total; a query
// by value scans from entry 1 until an entry exceeds the target; an update
// increments every entry above the symbol; a rescale, once the total
// reaches freq_limit, halves every entry, rounding up and keeping entries
// increasing; a table reset loads entry i with i, as the engine does after
// reset before it takes the first command; freq_limit resets to 65536.
// When res is stalled the result is held in an output register and the
// engine waits before its update pass; the queue accepts until it is full.
module adaptive_cum_freq_model_unit #(
    parameter int TABLE_ENTRIES = 258
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [24:0]  cfg_wr_data,
    acfm_cmd_if.sink     cmd,
    acfm_res_if.source   res
);

    logic [acfm_pkg::CNT_W-1:0] freq_limit_reg;
    logic                       q_valid;
    acfm_pkg::cmd_t             q_data;
    logic                       q_take;
    acfm_pkg::res_t             r_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_limit_reg <= 25'd65536;
        end
        else if (cfg_wr_en)
        begin
            freq_limit_reg <= cfg_wr_data;
        end
    end

    acfm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (q_valid),
        .cmd_data  (q_data),
        .cmd_take  (q_take)
    );

    acfm_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .freq_limit (freq_limit_reg),
        .cmd_valid  (q_valid),
        .cmd_data   (q_data),
        .cmd_take   (q_take),
        .res_valid  (res.valid),
        .res_data   (r_data),
        .res_ready  (res.ready)
    );

    assign res.found      = r_data.found;
    assign res.out_symbol = r_data.out_symbol;
    assign res.low_bound  = r_data.low_bound;
    assign res.high_bound = r_data.high_bound;
    assign res.total      = r_data.total;

endmodule
